/* rtl/core/quaternion_nlerp_shortest_macros.svh */
// Assertion helpers used by the checker file.
`ifndef QUATERNION_NLERP_SHORTEST_MACROS_SVH
`define QUATERNION_NLERP_SHORTEST_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("quaternion nlerp check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("quaternion nlerp check failed");

`endif

/* rtl/core/qnlerp_pkg.sv */
package qnlerp_pkg;

  localparam int CompBits  = 16;
  localparam int AlphaBits = 17;
  localparam int AlphaFrac = AlphaBits - 1;
  localparam logic [AlphaBits-1:0] AlphaOne = AlphaBits'(1) << AlphaFrac;
  localparam int Lanes     = 4;

  typedef struct packed {
    logic signed [CompBits-1:0] a_x;
    logic signed [CompBits-1:0] a_y;
    logic signed [CompBits-1:0] a_z;
    logic signed [CompBits-1:0] a_w;
    logic signed [CompBits-1:0] b_x;
    logic signed [CompBits-1:0] b_y;
    logic signed [CompBits-1:0] b_z;
    logic signed [CompBits-1:0] b_w;
    logic                       enable;
    logic                       last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [CompBits-1:0] q_x;
    logic signed [CompBits-1:0] q_y;
    logic signed [CompBits-1:0] q_z;
    logic signed [CompBits-1:0] q_w;
    logic                       written;
    logic                       last_out;
  } out_item_t;

endpackage

/* rtl/core/quaternion_nlerp_shortest.sv */
// Throughput: one word per cycle; the pipeline advances whenever the two-entry output
// buffer has room, so the rate is bounded only by how fast the sink takes words.
// Depth is set by the 31-step square root and the 16-step divider, one bit per stage.
// Reset: all stage valid bits and the output buffer clear; the alpha register returns to 0.
module quaternion_nlerp_shortest
  import qnlerp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [AlphaBits-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);

  // Datapath widths
  localparam int DW       = CompBits + 2;          // b - a and -b - a
  localparam int DotW     = 2 * CompBits + 2;      // exact dot product
  localparam int PW       = DW + AlphaBits + 1;    // (b - a) * alpha
  localparam int CW       = CompBits + 4;          // blended component
  localparam int MW       = CompBits + 1;          // blended magnitude
  localparam int MagBits  = 30;                    // block-scaled magnitude
  localparam int ScaleTop = MagBits - 1;
  localparam int ShW      = 5;
  localparam int SqW      = 2 * MagBits;
  localparam int SumBits  = SqW + 2;
  localparam int RootBits = SumBits / 2;
  localparam int RemW     = RootBits + 2;
  localparam int NW       = MagBits + CompBits + 1; // room for the rounding term
  localparam int QuotBits = CompBits;

  // Pipeline positions
  localparam int SqrtBase  = 9;
  localparam int NStage    = SqrtBase + RootBits;
  localparam int DivBase   = NStage + 1;
  localparam int NumStages = DivBase + QuotBits;

  localparam logic signed [PW-1:0] HalfVal = PW'(2 ** (AlphaFrac - 1));
  localparam logic [QuotBits-1:0]  PosMax  = QuotBits'((2 ** (CompBits - 1)) - 1);
  localparam logic [QuotBits-1:0]  NegMag  = QuotBits'(2 ** (CompBits - 1));

  typedef struct packed {
    logic             enable;
    logic             last;
    logic             zero;
    logic [Lanes-1:0] neg;
  } ctl_t;

  // ---------------------------------------------------------------------------
  // Configuration: clamp alpha to 1.0 on write
  // ---------------------------------------------------------------------------
  logic [AlphaBits-1:0] alpha_q, alpha_d;

  assign cfg_ready_o = 1'b1;
  assign alpha_d     = (cfg_data_i > AlphaOne) ? AlphaOne : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= '0;
    end else if (cfg_valid_i) begin
      alpha_q <= alpha_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Global advance: the whole pipe moves while the output buffer is not full.
  // The buffer count is a register, so in_ready_o has no path from out_ready_i.
  // ---------------------------------------------------------------------------
  logic [1:0] cnt_q, cnt_d;
  logic       adv;

  assign adv        = (cnt_q != 2'd2);
  assign in_ready_o = adv;

  logic [NumStages-1:0] vld_q;
  ctl_t                 ctl_q  [NumStages];
  ctl_t                 ctl_nx [NumStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Front stages
  // ---------------------------------------------------------------------------
  logic signed [CompBits-1:0]   in_a [Lanes];
  logic signed [CompBits-1:0]   in_b [Lanes];

  logic signed [CompBits-1:0]   s1_a [Lanes];
  logic signed [CompBits-1:0]   s1_b [Lanes];
  logic signed [2*CompBits-1:0] s2_prod [Lanes];
  logic signed [DW-1:0]         s2_dpos [Lanes];
  logic signed [DW-1:0]         s2_dneg [Lanes];
  logic signed [CompBits-1:0]   s2_a [Lanes];
  logic signed [DW-1:0]         s3_d [Lanes];
  logic signed [CompBits-1:0]   s3_a [Lanes];
  logic signed [PW-1:0]         s4_p [Lanes];
  logic signed [CompBits-1:0]   s4_a [Lanes];
  logic [MW-1:0]                s5_mag [Lanes];
  logic [MW-1:0]                s6_mag [Lanes];
  logic [ShW-1:0]               s6_shl;
  logic [MagBits-1:0]           s7_smag [Lanes];
  logic [SqW-1:0]               s8_sq [Lanes];
  logic [MagBits-1:0]           s8_smag [Lanes];
  logic [SumBits-1:0]           s9_l2;
  logic [MagBits-1:0]           s9_smag [Lanes];

  logic signed [2*CompBits-1:0] prod2 [Lanes];
  logic signed [DW-1:0]         dpos2 [Lanes];
  logic signed [DW-1:0]         dneg2 [Lanes];
  logic signed [DotW-1:0]       dot3;
  logic                         flip3;
  logic signed [PW-1:0]         p4 [Lanes];
  logic signed [PW-1:0]         t5 [Lanes];
  logic signed [PW-1:0]         sh5 [Lanes];
  logic signed [CW-1:0]         c5 [Lanes];
  logic [MW-1:0]                mag5 [Lanes];
  logic [Lanes-1:0]             neg5;
  logic [MW-1:0]                orv6;
  logic [ShW-1:0]               msb6;
  logic [ShW-1:0]               shl6;
  logic                         zero6;
  logic [MagBits-1:0]           smag7 [Lanes];
  logic [SqW-1:0]               sq8 [Lanes];
  logic [SumBits-1:0]           l2_9;

  assign in_a[0] = in_data_i.a_x;
  assign in_a[1] = in_data_i.a_y;
  assign in_a[2] = in_data_i.a_z;
  assign in_a[3] = in_data_i.a_w;
  assign in_b[0] = in_data_i.b_x;
  assign in_b[1] = in_data_i.b_y;
  assign in_b[2] = in_data_i.b_z;
  assign in_b[3] = in_data_i.b_w;

  always_comb begin
    // Products for the sign of a.b, and both candidate differences
    for (int i = 0; i < Lanes; i++) begin
      prod2[i] = s1_a[i] * s1_b[i];
      dpos2[i] = DW'(s1_b[i]) - DW'(s1_a[i]);
      dneg2[i] = -DW'(s1_b[i]) - DW'(s1_a[i]);
    end
    // Take the short arc: negate b when the dot product is negative
    dot3 = DotW'(s2_prod[0]) + DotW'(s2_prod[1]) + DotW'(s2_prod[2]) + DotW'(s2_prod[3]);
    flip3 = dot3[DotW-1];
    // Blend: a + floor(((b - a) * alpha + half) / one)
    for (int i = 0; i < Lanes; i++) begin
      p4[i]   = s3_d[i] * $signed({1'b0, alpha_q});
      t5[i]   = s4_p[i] + HalfVal;
      sh5[i]  = t5[i] >>> AlphaFrac;
      c5[i]   = CW'(s4_a[i]) + CW'(sh5[i]);
      neg5[i] = c5[i][CW-1];
      mag5[i] = c5[i][CW-1] ? MW'(-c5[i]) : MW'(c5[i]);
    end
    // Block scale: the top bit of the OR of all magnitudes is that of the largest
    orv6 = s5_mag[0] | s5_mag[1] | s5_mag[2] | s5_mag[3];
    msb6 = '0;
    for (int j = 0; j < MW; j++) begin
      if (orv6[j]) begin
        msb6 = ShW'(j);
      end
    end
    shl6  = ShW'(ScaleTop) - msb6;
    zero6 = (orv6 == '0);
    for (int i = 0; i < Lanes; i++) begin
      smag7[i] = MagBits'(s6_mag[i]) << s6_shl;
      sq8[i]   = s7_smag[i] * s7_smag[i];
    end
    l2_9 = SumBits'(s8_sq[0]) + SumBits'(s8_sq[1]) + SumBits'(s8_sq[2]) + SumBits'(s8_sq[3]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < Lanes; i++) begin
        s1_a[i]    <= in_a[i];
        s1_b[i]    <= in_b[i];
        s2_prod[i] <= prod2[i];
        s2_dpos[i] <= dpos2[i];
        s2_dneg[i] <= dneg2[i];
        s2_a[i]    <= s1_a[i];
        s3_d[i]    <= flip3 ? s2_dneg[i] : s2_dpos[i];
        s3_a[i]    <= s2_a[i];
        s4_p[i]    <= p4[i];
        s4_a[i]    <= s3_a[i];
        s5_mag[i]  <= mag5[i];
        s6_mag[i]  <= s5_mag[i];
        s7_smag[i] <= smag7[i];
        s8_sq[i]   <= sq8[i];
        s8_smag[i] <= s7_smag[i];
        s9_smag[i] <= s8_smag[i];
      end
      s6_shl <= shl6;
      s9_l2  <= l2_9;
    end
  end

  // Control travels with the data; sign and zero flags join once known
  always_comb begin
    ctl_nx[0].enable = in_data_i.enable;
    ctl_nx[0].last   = in_data_i.last_in;
    ctl_nx[0].zero   = 1'b0;
    ctl_nx[0].neg    = '0;
    for (int k = 1; k < NumStages; k++) begin
      ctl_nx[k] = ctl_q[k-1];
    end
    ctl_nx[4].neg  = neg5;
    ctl_nx[5].zero = zero6;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumStages; k++) begin
        ctl_q[k] <= ctl_nx[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Square root of the squared length, one root bit per stage
  // ---------------------------------------------------------------------------
  logic [RemW-1:0]     sr_rem_q  [RootBits];
  logic [RootBits-1:0] sr_root_q [RootBits];
  logic [SumBits-1:0]  sr_v_q    [RootBits];
  logic [MagBits-1:0]  sr_mag_q  [RootBits][Lanes];

  for (genvar k = 0; k < RootBits; k++) begin : g_sqrt
    logic [RemW-1:0]     rem_in;
    logic [RootBits-1:0] root_in;
    logic [SumBits-1:0]  v_in;
    logic [MagBits-1:0]  mag_in [Lanes];
    logic [RemW+1:0]     wide;
    logic [RemW+1:0]     trial;
    logic                ge;

    if (k == 0) begin : g_head
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = s9_l2;
      assign mag_in  = s9_smag;
    end else begin : g_tail
      assign rem_in  = sr_rem_q[k-1];
      assign root_in = sr_root_q[k-1];
      assign v_in    = sr_v_q[k-1];
      assign mag_in  = sr_mag_q[k-1];
    end

    always_comb begin
      wide  = {rem_in, v_in[SumBits-1:SumBits-2]};
      trial = (RemW + 2)'({root_in, 2'b01});
      ge    = (wide >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sr_rem_q[k]  <= ge ? RemW'(wide - trial) : RemW'(wide);
        sr_root_q[k] <= {root_in[RootBits-2:0], ge};
        sr_v_q[k]    <= v_in << 2;
        for (int i = 0; i < Lanes; i++) begin
          sr_mag_q[k][i] <= mag_in[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Rounded numerators, then one quotient bit per stage in each lane
  // ---------------------------------------------------------------------------
  logic [NW-1:0]       n_q [Lanes];
  logic [RootBits-1:0] n_r_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < Lanes; i++) begin
        n_q[i] <= (NW'(sr_mag_q[RootBits-1][i]) << (CompBits - 1))
                  + NW'(sr_root_q[RootBits-1] >> 1);
      end
      n_r_q <= sr_root_q[RootBits-1];
    end
  end

  logic [RootBits-1:0] dv_rem_q [QuotBits][Lanes];
  logic [QuotBits-1:0] dv_low_q [QuotBits][Lanes];
  logic [QuotBits-1:0] dv_quo_q [QuotBits][Lanes];
  logic [RootBits-1:0] dv_r_q   [QuotBits];

  for (genvar j = 0; j < QuotBits; j++) begin : g_div
    logic [RootBits-1:0] rem_in [Lanes];
    logic [QuotBits-1:0] low_in [Lanes];
    logic [QuotBits-1:0] quo_in [Lanes];
    logic [RootBits-1:0] r_in;
    logic [RootBits:0]   w      [Lanes];
    logic [Lanes-1:0]    ge;

    if (j == 0) begin : g_head
      always_comb begin
        r_in = n_r_q;
        for (int i = 0; i < Lanes; i++) begin
          rem_in[i] = RootBits'(n_q[i][NW-1:QuotBits]);
          low_in[i] = n_q[i][QuotBits-1:0];
          quo_in[i] = '0;
        end
      end
    end else begin : g_tail
      always_comb begin
        r_in = dv_r_q[j-1];
        for (int i = 0; i < Lanes; i++) begin
          rem_in[i] = dv_rem_q[j-1][i];
          low_in[i] = dv_low_q[j-1][i];
          quo_in[i] = dv_quo_q[j-1][i];
        end
      end
    end

    always_comb begin
      for (int i = 0; i < Lanes; i++) begin
        w[i]  = {rem_in[i], low_in[i][QuotBits-1]};
        ge[i] = (w[i] >= {1'b0, r_in});
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int i = 0; i < Lanes; i++) begin
          dv_rem_q[j][i] <= ge[i] ? RootBits'(w[i] - {1'b0, r_in}) : RootBits'(w[i]);
          dv_low_q[j][i] <= low_in[i] << 1;
          dv_quo_q[j][i] <= {quo_in[i][QuotBits-2:0], ge[i]};
        end
        dv_r_q[j] <= r_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sign, saturate, and drop masked or zero-length words to zero
  // ---------------------------------------------------------------------------
  ctl_t                       fin_ctl;
  logic [QuotBits-1:0]        fin_mag [Lanes];
  logic signed [CompBits-1:0] fin_val [Lanes];
  out_item_t                  fin_word;

  assign fin_ctl = ctl_q[NumStages-1];

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      if (fin_ctl.neg[i]) begin
        fin_mag[i] = (dv_quo_q[QuotBits-1][i] > NegMag) ? NegMag : dv_quo_q[QuotBits-1][i];
        fin_val[i] = CompBits'(-fin_mag[i]);
      end else begin
        fin_mag[i] = (dv_quo_q[QuotBits-1][i] > PosMax) ? PosMax : dv_quo_q[QuotBits-1][i];
        fin_val[i] = CompBits'(fin_mag[i]);
      end
      if (!fin_ctl.enable || fin_ctl.zero) begin
        fin_val[i] = '0;
      end
    end
    fin_word.q_x      = fin_val[0];
    fin_word.q_y      = fin_val[1];
    fin_word.q_z      = fin_val[2];
    fin_word.q_w      = fin_val[3];
    fin_word.written  = fin_ctl.enable;
    fin_word.last_out = fin_ctl.last;
  end

  // ---------------------------------------------------------------------------
  // Two-entry output buffer: hold finished words while the sink stalls
  // ---------------------------------------------------------------------------
  out_item_t obuf_q [2];
  logic      wptr_q, rptr_q;
  logic      push, pop;

  assign push        = adv && vld_q[NumStages-1];
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = obuf_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      obuf_q[wptr_q] <= fin_word;
    end
  end

endmodule

/* rtl/core/qnlerp_checker.sv */
`include "quaternion_nlerp_shortest_macros.svh"

module qnlerp_checker
  import qnlerp_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input out_item_t            out_data_o
);

  // Hold a stalled result word
  `QN_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // Drop input ready only when finished words are backed up
  `QN_ASSERT_NOW(a_ready_backpressure, !in_ready_o, out_valid_o)

  // A skipped word carries zero components
  `QN_ASSERT_NOW(a_masked_zero, out_valid_o && !out_data_o.written,
    out_data_o.q_x == '0 && out_data_o.q_y == '0 && out_data_o.q_z == '0 && out_data_o.q_w == '0)

endmodule

bind quaternion_nlerp_shortest qnlerp_checker u_qnlerp_checker (.*);
